// ===== src/ddo_pkg.sv =====
// shared types, constants and the arctangent table of the odometry block
// used by every module of differential_drive_odometry; depends on nothing
package ddo_pkg;

    localparam int W_OPND = 34;   // multiplier operands and trig values
    localparam int W_PROD = 68;   // full product
    localparam int W_NUM  = 68;   // divider dividend magnitude
    localparam int W_DEN  = 48;   // divider divisor magnitude
    localparam int W_DA   = 48;   // heading change before reduction

    localparam logic signed [33:0] Q29_PI      = 34'sd1686629713;
    localparam logic signed [33:0] Q29_TWO_PI  = 34'sd3373259426;
    localparam logic signed [33:0] Q29_HALF_PI = 34'sd843314857;
    localparam logic signed [33:0] Q29_GAIN    = 34'sd326016437;

    localparam logic [1:0] CFG_CM_PER_TICK = 2'd0;
    localparam logic [1:0] CFG_INV_TRACK   = 2'd1;

    localparam logic [23:0] CM_PER_TICK_RST = 24'd1463980;
    localparam logic [23:0] INV_TRACK_RST   = 24'd745654;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_DL,
        OP_MUL_DR,
        OP_MUL_DA,
        OP_CORDIC_H,
        OP_STRAIGHT_Y,
        OP_STRAIGHT_X,
        OP_DIV_MOD,
        OP_CORDIC_H2,
        OP_MUL_Y,
        OP_DIV_Y,
        OP_MUL_X,
        OP_DIV_X,
        OP_COMMIT
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic da_zero;
    } t_stat;

    function automatic logic [28:0] atan_q29(input logic [4:0] i);
        unique case (i)
            5'd0:  return 29'd421657428;
            5'd1:  return 29'd248918915;
            5'd2:  return 29'd131521918;
            5'd3:  return 29'd66762579;
            5'd4:  return 29'd33510843;
            5'd5:  return 29'd16771758;
            5'd6:  return 29'd8387925;
            5'd7:  return 29'd4194219;
            5'd8:  return 29'd2097141;
            5'd9:  return 29'd1048575;
            5'd10: return 29'd524288;
            5'd11: return 29'd262144;
            5'd12: return 29'd131072;
            5'd13: return 29'd65536;
            5'd14: return 29'd32768;
            5'd15: return 29'd16384;
            5'd16: return 29'd8192;
            5'd17: return 29'd4096;
            5'd18: return 29'd2048;
            5'd19: return 29'd1024;
            5'd20: return 29'd512;
            5'd21: return 29'd256;
            5'd22: return 29'd128;
            5'd23: return 29'd64;
            5'd24: return 29'd32;
            5'd25: return 29'd16;
            5'd26: return 29'd8;
            5'd27: return 29'd4;
            5'd28: return 29'd2;
            5'd29: return 29'd1;
            default: return 29'd0;
        endcase
    endfunction

endpackage

// ===== src/ddo_cordic.sv =====
// iterative rotation-mode cordic giving cosine and sine of a Q3.29 angle
// one rotation per cycle; depends on ddo_pkg
module ddo_cordic #(
    parameter int STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [33:0]  i_angle,
    output logic                o_done,
    output logic signed [33:0]  o_cos,
    output logic signed [33:0]  o_sin
);
    import ddo_pkg::*;

    localparam int W_I = $clog2(STEPS);

    logic signed [33:0] r_x, r_y, r_z;
    logic               r_neg, r_busy, r_done;
    logic [W_I-1:0]     r_i;

    logic signed [33:0] w_z0, w_xs, w_ys, w_at;
    logic               w_neg0;

    // fold into the half-circle around zero
    always_comb begin
        w_z0   = i_angle;
        w_neg0 = 1'b0;
        if (i_angle > Q29_HALF_PI) begin
            w_z0   = i_angle - Q29_PI;
            w_neg0 = 1'b1;
        end else if (i_angle < -Q29_HALF_PI) begin
            w_z0   = i_angle + Q29_PI;
            w_neg0 = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = $signed({5'b0, atan_q29(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= Q29_GAIN;
                r_y    <= '0;
                r_z    <= w_z0;
                r_neg  <= w_neg0;
                r_i    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 1'b1;
                if (r_i == W_I'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;

endmodule

// ===== src/ddo_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// depends on ddo_pkg for the operand widths
module ddo_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ddo_pkg::W_NUM-1:0]  i_num,
    input  logic [ddo_pkg::W_DEN-1:0]  i_den,
    output logic                       o_done,
    output logic [ddo_pkg::W_NUM-1:0]  o_quo
);
    import ddo_pkg::*;

    localparam int W_CNT = $clog2(W_NUM + 1);

    logic [W_NUM-1:0] r_quo;
    logic [W_DEN-1:0] r_rem, r_den;
    logic [W_CNT-1:0] r_cnt;
    logic             r_busy, r_done;

    logic [W_DEN:0]   w_trial, w_sub;
    logic             w_ge;

    assign w_trial = {r_rem, r_quo[W_NUM-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sub   = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[W_DEN-1:0] : w_trial[W_DEN-1:0];
                r_quo <= {r_quo[W_NUM-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == W_CNT'(W_NUM - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== src/ddo_dp.sv =====
// odometry datapath: pose state, two-phase multiplier, cordic and divider
// depends on ddo_pkg, ddo_cordic and ddo_div
module ddo_dp #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data,
    input  ddo_pkg::t_cmd       i_cmd,
    input  logic signed [31:0]  i_left_count,
    input  logic signed [31:0]  i_right_count,
    output ddo_pkg::t_stat      o_stat,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic signed [31:0]  o_heading
);
    import ddo_pkg::*;

    typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_POST} t_mph;

    // turn reduction: 2*pi shifted up past the largest turn, three
    // compare and subtract steps per cycle
    localparam logic [W_DEN-1:0] RD_DEN_TOP = W_DEN'(Q29_TWO_PI) << 14;
    localparam logic [2:0]       RD_LAST    = 3'd4;

    logic [23:0]            r_cpt, r_itw;
    logic signed [31:0]     r_last_l, r_last_r, r_x, r_y, r_head;
    logic signed [31:0]     r_in_l, r_in_r, r_dl, r_dr, r_dx, r_dy, r_h2;
    logic signed [W_DA-1:0] r_da;
    logic signed [33:0]     r_ch, r_sh, r_c2, r_s2, r_ma, r_mb;
    logic signed [67:0]     r_prod;
    logic                   r_qneg, r_done;
    t_mph                   r_mph;
    t_op                    r_cur;
    logic [W_DEN-1:0]       r_rd_rem, r_rd_den;
    logic [2:0]             r_rd_cnt;
    logic                   r_rd_busy, r_rd_fin;

    logic signed [31:0]     w_tick_l, w_tick_r;
    logic signed [33:0]     w_ma, w_mb, w_ang, w_cos, w_sin;
    logic signed [51:0]     w_plo;
    logic signed [50:0]     w_phi;
    logic signed [67:0]     w_r8, w_r11, w_r29;
    logic                   w_mul_op, w_div_op, w_cor_op, w_cor_done, w_div_done;
    logic [W_NUM-1:0]       w_num, w_quo;
    logic [W_DEN-1:0]       w_den, w_da_mag;
    logic [W_DEN-1:0]       w_rd_s0, w_rd_s1, w_rd_s2;
    logic signed [33:0]     w_rem34, w_red0, w_red1, w_h2a, w_h2;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(v);
    endfunction

    assign w_tick_l = r_in_l - r_last_l;
    assign w_tick_r = r_in_r - r_last_r;

    assign w_mul_op = i_cmd.op == OP_MUL_DL || i_cmd.op == OP_MUL_DR ||
                      i_cmd.op == OP_MUL_DA || i_cmd.op == OP_STRAIGHT_Y ||
                      i_cmd.op == OP_STRAIGHT_X || i_cmd.op == OP_MUL_Y ||
                      i_cmd.op == OP_MUL_X;
    assign w_div_op = i_cmd.op == OP_DIV_Y || i_cmd.op == OP_DIV_X;
    assign w_cor_op = i_cmd.op == OP_CORDIC_H || i_cmd.op == OP_CORDIC_H2;

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            OP_MUL_DL: begin
                w_ma = 34'(w_tick_l);
                w_mb = $signed({10'b0, r_cpt});
            end
            OP_MUL_DR: begin
                w_ma = 34'(w_tick_r);
                w_mb = $signed({10'b0, r_cpt});
            end
            OP_MUL_DA: begin
                w_ma = 34'(r_dl) - 34'(r_dr);
                w_mb = $signed({10'b0, r_itw});
            end
            OP_STRAIGHT_Y: begin
                w_ma = 34'(r_dr);
                w_mb = r_ch;
            end
            OP_STRAIGHT_X: begin
                w_ma = 34'(r_dr);
                w_mb = r_sh;
            end
            OP_MUL_Y: begin
                w_ma = 34'(r_dl) + 34'(r_dr);
                w_mb = r_s2 - r_sh;
            end
            OP_MUL_X: begin
                w_ma = 34'(r_dl) + 34'(r_dr);
                w_mb = r_ch - r_c2;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_plo = r_ma * $signed({1'b0, r_mb[16:0]});
    assign w_phi = r_ma * $signed(r_mb[33:17]);

    assign w_r8  = (r_prod + 68'sd128) >>> 8;
    assign w_r11 = (r_prod + 68'sd1024) >>> 11;
    assign w_r29 = (r_prod + 68'sd268435456) >>> 29;

    assign w_ang = (i_cmd.op == OP_CORDIC_H2) ? 34'(r_h2) : 34'(r_head);

    ddo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && w_cor_op),
        .i_angle (w_ang),
        .o_done  (w_cor_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    assign w_da_mag = r_da[W_DA-1] ? W_DEN'(-r_da) : W_DEN'(r_da);

    assign w_num = r_prod[67] ? W_NUM'(-r_prod) : W_NUM'(r_prod);
    assign w_den = {w_da_mag[W_DEN-2:0], 1'b0};

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start && w_div_op),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_rd_s0 = (r_rd_rem >= r_rd_den) ? r_rd_rem - r_rd_den : r_rd_rem;
        w_rd_s1 = (w_rd_s0 >= (r_rd_den >> 1)) ? w_rd_s0 - (r_rd_den >> 1) : w_rd_s0;
        w_rd_s2 = (w_rd_s1 >= (r_rd_den >> 2)) ? w_rd_s1 - (r_rd_den >> 2) : w_rd_s1;
    end

    // reduce the turn, then wrap the new heading
    always_comb begin
        w_rem34 = $signed({2'b0, r_rd_rem[31:0]});
        w_red0  = r_da[W_DA-1] ? -w_rem34 : w_rem34;
        if (w_red0 > Q29_PI)
            w_red1 = w_red0 - Q29_TWO_PI;
        else if (w_red0 < -Q29_PI)
            w_red1 = w_red0 + Q29_TWO_PI;
        else
            w_red1 = w_red0;
        w_h2a = 34'(r_head) + w_red1;
        if (w_h2a > Q29_PI)
            w_h2 = w_h2a - Q29_TWO_PI;
        else if (w_h2a < -Q29_PI)
            w_h2 = w_h2a + Q29_TWO_PI;
        else
            w_h2 = w_h2a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt     <= CM_PER_TICK_RST;
            r_itw     <= INV_TRACK_RST;
            r_last_l  <= '0;
            r_last_r  <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_head    <= '0;
            r_mph     <= MP_IDLE;
            r_done    <= 1'b0;
            r_cur     <= OP_NONE;
            r_rd_busy <= 1'b0;
            r_rd_fin  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                priority if (i_cfg_idx == CFG_CM_PER_TICK)
                    r_cpt <= i_cfg_data;
                else if (i_cfg_idx == CFG_INV_TRACK)
                    r_itw <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_in_l <= i_left_count;
                r_in_r <= i_right_count;
            end
            if (i_cmd.start) begin
                r_cur <= i_cmd.op;
                if (w_mul_op) begin
                    r_ma  <= w_ma;
                    r_mb  <= w_mb;
                    r_mph <= MP_LO;
                end
                if (w_div_op)
                    r_qneg <= r_prod[67] ^ r_da[W_DA-1];
                if (i_cmd.op == OP_DIV_MOD) begin
                    r_rd_rem  <= w_da_mag;
                    r_rd_den  <= RD_DEN_TOP;
                    r_rd_cnt  <= '0;
                    r_rd_busy <= 1'b1;
                end
                if (i_cmd.op == OP_COMMIT) begin
                    r_x      <= r_x + r_dx;
                    r_y      <= r_y + r_dy;
                    r_last_l <= r_in_l;
                    r_last_r <= r_in_r;
                    if (r_da != '0)
                        r_head <= r_h2;
                end
            end
            if (r_rd_busy) begin
                r_rd_rem <= w_rd_s2;
                r_rd_den <= r_rd_den >> 3;
                r_rd_cnt <= r_rd_cnt + 1'b1;
                if (r_rd_cnt == RD_LAST) begin
                    r_rd_busy <= 1'b0;
                    r_rd_fin  <= 1'b1;
                end
            end
            if (r_rd_fin) begin
                r_rd_fin <= 1'b0;
                r_done   <= 1'b1;
                r_h2     <= 32'(w_h2);
            end
            unique case (r_mph)
                MP_LO: begin
                    r_prod <= 68'(w_plo);
                    r_mph  <= MP_HI;
                end
                MP_HI: begin
                    r_prod <= r_prod + (68'(w_phi) <<< 17);
                    r_mph  <= MP_POST;
                end
                MP_POST: begin
                    r_mph  <= MP_IDLE;
                    r_done <= 1'b1;
                    unique case (r_cur)
                        OP_MUL_DL:     r_dl <= sat32(w_r8);
                        OP_MUL_DR:     r_dr <= sat32(w_r8);
                        OP_MUL_DA:     r_da <= W_DA'(w_r11);
                        OP_STRAIGHT_Y: r_dy <= 32'(w_r29);
                        OP_STRAIGHT_X: r_dx <= 32'(w_r29);
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (w_cor_done) begin
                r_done <= 1'b1;
                if (r_cur == OP_CORDIC_H2) begin
                    r_c2 <= w_cos;
                    r_s2 <= w_sin;
                end else begin
                    r_ch <= w_cos;
                    r_sh <= w_sin;
                end
            end
            if (w_div_done) begin
                r_done <= 1'b1;
                unique case (r_cur)
                    OP_DIV_Y:   r_dy <= r_qneg ? -w_quo[31:0] : w_quo[31:0];
                    OP_DIV_X:   r_dx <= r_qneg ? -w_quo[31:0] : w_quo[31:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.da_zero = r_da == '0;
    assign o_pos_x        = r_x;
    assign o_pos_y        = r_y;
    assign o_heading      = r_head;

endmodule

// ===== src/ddo_ctrl.sv =====
// odometry sequencer: steps the datapath through one pose update per item
// and owns both stream handshakes; depends on ddo_pkg
module ddo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    output ddo_pkg::t_cmd  o_cmd,
    input  ddo_pkg::t_stat i_stat
);
    import ddo_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_COMMIT, S_PUB} t_state;

    t_state r_state;
    logic   r_start, r_valid;
    t_op    r_op;

    assign o_s_ready   = r_state == S_IDLE;
    assign o_m_valid   = r_valid;
    assign o_cmd.load  = i_s_valid && o_s_ready;
    assign o_cmd.start = r_start;
    assign o_cmd.op    = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_op    <= OP_NONE;
            r_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_valid && i_m_ready)
                r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_valid) begin
                        r_state <= S_RUN;
                        r_start <= 1'b1;
                        r_op    <= OP_MUL_DL;
                    end
                end
                S_RUN: begin
                    if (i_stat.done) begin
                        r_start <= 1'b1;
                        unique case (r_op)
                            OP_MUL_DL:     r_op <= OP_MUL_DR;
                            OP_MUL_DR:     r_op <= OP_MUL_DA;
                            OP_MUL_DA:     r_op <= OP_CORDIC_H;
                            OP_CORDIC_H:
                                r_op <= i_stat.da_zero ? OP_STRAIGHT_Y : OP_DIV_MOD;
                            OP_STRAIGHT_Y: r_op <= OP_STRAIGHT_X;
                            OP_DIV_MOD:    r_op <= OP_CORDIC_H2;
                            OP_CORDIC_H2:  r_op <= OP_MUL_Y;
                            OP_MUL_Y:      r_op <= OP_DIV_Y;
                            OP_DIV_Y:      r_op <= OP_MUL_X;
                            OP_MUL_X:      r_op <= OP_DIV_X;
                            OP_STRAIGHT_X, OP_DIV_X: begin
                                r_start <= 1'b0;
                                r_state <= S_COMMIT;
                            end
                            default: begin
                                r_start <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                // pose registers are the output payload: wait until it is free
                S_COMMIT: begin
                    if (!r_valid || i_m_ready) begin
                        r_start <= 1'b1;
                        r_op    <= OP_COMMIT;
                        r_state <= S_PUB;
                    end
                end
                S_PUB: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/differential_drive_odometry_top.sv =====
// top level of the differential-drive wheel odometry block
// instantiates ddo_ctrl and ddo_dp; depends on ddo_pkg
//
// usage:
//   slave stream carries the absolute left and right encoder counts, master
//   stream carries the pose (x, y in Q16.16 cm, heading in Q3.29 rad).
//   every input transaction gives exactly one output transaction.
//   the configuration port writes cm_per_tick (index 0) and inv_track_width
//   (index 1); write it only while no item is in flight.
// sequence:
//   one item at a time; a straight move takes five multiplies and one cordic
//   pass. an arc takes two serial divides for y and x, two cordic passes and
//   a turn reduction; tready returns with tvalid
// reset:
//   synchronous active-low; clears pose, previous counts and loads the
//   default register values. no output is pending after reset.
// stall:
//   the pose stays on the master stream until taken; a finished update
//   waits before committing while the previous pose is still unread.
module differential_drive_odometry_top #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [23:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // left_count, right_count
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata    // pos_x, pos_y, heading
);
    import ddo_pkg::*;

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic signed [31:0] w_pos_x, w_pos_y, w_heading;

    ddo_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_cmd     (w_cmd),
        .i_stat    (w_stat)
    );

    ddo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_left_count  (i_s_axis_tdata[31:0]),
        .i_right_count (i_s_axis_tdata[63:32]),
        .o_stat        (w_stat),
        .o_pos_x       (w_pos_x),
        .o_pos_y       (w_pos_y),
        .o_heading     (w_heading)
    );

    assign o_m_axis_tdata = {w_heading, w_pos_y, w_pos_x};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted twice in a row");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (34'(w_heading) <= Q29_PI && 34'(w_heading) >= -Q29_PI))
        else $error("heading outside plus or minus pi");

    a_valid_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_cmd.start && w_cmd.op == OP_COMMIT))
        else $error("pose shown without a commit");

endmodule
